### hw/rtl/masked_score_statistics_core_defines.svh
// assertion macros for the masked score statistics core
`ifndef MASKED_SCORE_STATISTICS_CORE_DEFINES_SVH
`define MASKED_SCORE_STATISTICS_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MSS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define MSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### hw/rtl/mss_pkg.sv
// package with types and constants of the masked score statistics core
`default_nettype none
package mss_pkg;
	localparam int unsigned MAX_SAMPLES_DEF = 65536;
	localparam int unsigned NUM_SETS_DEF = 4;
	localparam int unsigned VAL_W = 24;
	localparam int unsigned MAXV_W = 23;
	localparam int unsigned SUM_W = 40;
	localparam int unsigned SQ_W = 64;
	localparam int unsigned CNT_W = 17;
	localparam int unsigned SET_W = 2;
	localparam int unsigned ENT_W = VAL_W + MAXV_W + SUM_W + SQ_W + CNT_W;

	// one memory entry of per-set statistics
	typedef struct packed {
		logic [VAL_W-1:0]  min_v;
		logic [MAXV_W-1:0] max_v;
		logic [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]   sq;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	// request from the accumulator to the report unit
	typedef struct packed {
		logic [SET_W-1:0]  set;
		logic [VAL_W-1:0]  min_v;
		logic [MAXV_W-1:0] max_v;
		logic [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]   sq;
		logic [CNT_W-1:0]  cnt;
	} rep_req_t;

	function automatic entry_t clear_entry();
		entry_t e;
		e.min_v = '1;
		e.max_v = '0;
		e.sum = '0;
		e.sq = '0;
		e.cnt = '0;
		return e;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/mss_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module mss_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/mss_report.sv
// report unit: iterative divider for mean, variance and square root
`default_nettype none
module mss_report (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire mss_pkg::rep_req_t req,
	output logic                   busy,
	output logic                   valid,
	input  wire logic              stall,
	output logic [1:0]             report_set,
	output logic [23:0]            min_value,
	output logic [22:0]            max_value,
	output logic [23:0]            mean_value,
	output logic [23:0]            std_dev,
	output logic [16:0]            valid_count,
	output logic                   empty_res
);
	import mss_pkg::*;
	`include "masked_score_statistics_core_defines.svh"

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_VAR   = 7'b0000100,
		ST_DIV1  = 7'b0001000,
		ST_DIV2  = 7'b0010000,
		ST_SQRT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} st_t;

	st_t              st_q;
	rep_req_t         r_q;
	logic [127:0]     acc_q;      // n*sq
	logic [127:0]     s2_q;       // sum squared
	logic [127:0]     num_q;      // dividend / quotient register
	logic [CNT_W:0]   rem_q;      // divider remainder
	logic [6:0]       cnt_q;      // bit counter
	logic [63:0]      x_q, root_q, bit_q;
	logic [63:0]      mulp;
	logic [31:0]      mul_a, mul_b;
	logic [2:0]       part_q;

	// one 32x32 partial product per cycle: n*sq in two halves, then sum*sum in 20-bit pieces
	always_comb begin
		case (part_q)
			3'd0: begin
				mul_a = r_q.sq[31:0];
				mul_b = {15'd0, r_q.cnt};
			end
			3'd1: begin
				mul_a = r_q.sq[63:32];
				mul_b = {15'd0, r_q.cnt};
			end
			3'd2: begin
				mul_a = {12'd0, r_q.sum[19:0]};
				mul_b = {12'd0, r_q.sum[19:0]};
			end
			3'd3: begin
				mul_a = {12'd0, r_q.sum[39:20]};
				mul_b = {12'd0, r_q.sum[19:0]};
			end
			default: begin
				mul_a = {12'd0, r_q.sum[39:20]};
				mul_b = {12'd0, r_q.sum[39:20]};
			end
		endcase
	end
	assign mulp = mul_a * mul_b;

	// shared restoring divider step by count
	logic [CNT_W+1:0] trial;
	logic             fits;
	assign trial = {rem_q, num_q[127]} - {2'b0, r_q.cnt};
	assign fits  = !trial[CNT_W+1];

	// square root step
	logic [63:0] sq_t;
	logic        sq_ge;
	assign sq_t  = root_q + bit_q;
	assign sq_ge = x_q >= sq_t;

	assign busy = (st_q != ST_IDLE);
	assign valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						r_q <= req;
						acc_q <= '0;
						part_q <= '0;
						if (req.cnt == '0) st_q <= ST_OUT;
						else st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					case (part_q)
						3'd0: acc_q <= {64'd0, mulp};
						3'd1: acc_q <= acc_q + {32'd0, mulp, 32'd0};
						3'd2: s2_q <= {64'd0, mulp};
						3'd3: s2_q <= s2_q + {43'd0, mulp, 21'd0};
						default: s2_q <= s2_q + {24'd0, mulp, 40'd0};
					endcase
					if (part_q == 3'd4) st_q <= ST_VAR;
					part_q <= part_q + 3'd1;
				end
				ST_VAR: begin
					// variance numerator, clamped at zero
					if (acc_q < s2_q) num_q <= '0;
					else num_q <= acc_q - s2_q;
					rem_q <= '0;
					cnt_q <= '0;
					st_q <= ST_DIV1;
				end
				ST_DIV1, ST_DIV2: begin
					rem_q <= fits ? trial[CNT_W:0] : {rem_q[CNT_W-1:0], num_q[127]};
					num_q <= {num_q[126:0], fits};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						cnt_q <= '0;
						if (st_q == ST_DIV1) begin
							// divide the quotient by n once more
							st_q <= ST_DIV2;
						end else begin
							st_q <= ST_SQRT;
						end
						rem_q <= '0;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 7'd0) begin
						x_q <= num_q[63:0];
						root_q <= '0;
						bit_q <= 64'd1 << 62;
						cnt_q <= 7'd1;
					end else if (bit_q == '0) begin
						st_q <= ST_OUT;
					end else begin
						if (sq_ge) begin
							x_q <= x_q - sq_t;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				ST_OUT: begin
					if (!stall) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// mean by a separate serial divider running alongside
	logic [SUM_W-1:0] mq_q;
	logic [CNT_W:0]   mr_q;
	logic [CNT_W+1:0] mtrial;
	logic [5:0]       mc_q;
	assign mtrial = {mr_q, mq_q[SUM_W-1]} - {2'b0, r_q.cnt};
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			mq_q <= req.sum;
			mr_q <= '0;
			mc_q <= '0;
		end else if (mc_q != 6'(SUM_W)) begin
			mr_q <= !mtrial[CNT_W+1] ? mtrial[CNT_W:0] : {mr_q[CNT_W-1:0], mq_q[SUM_W-1]};
			mq_q <= {mq_q[SUM_W-2:0], !mtrial[CNT_W+1]};
			mc_q <= mc_q + 6'd1;
		end
	end

	// result fields
	assign empty_res   = (r_q.cnt == '0);
	assign report_set  = r_q.set;
	assign valid_count = r_q.cnt;
	assign min_value   = empty_res ? '1 : r_q.min_v;
	assign max_value   = empty_res ? '0 : r_q.max_v;
	assign mean_value  = empty_res ? '1 : mq_q[23:0];
	assign std_dev     = empty_res ? '1 : root_q[23:0];

	`MSS_ASSERT_NEXT(a_out_then_idle, valid && !stall, !busy)
	`MSS_ASSERT_NEXT(a_take_leaves_idle, (st_q == ST_IDLE) && req_valid, busy)
	`MSS_ASSERT_IMPL(a_empty_flag, valid && empty_res, std_dev == 24'hffffff)
endmodule
`default_nettype wire

### hw/rtl/masked_score_statistics_core.sv
// top level of the masked score statistics core
// channel | dir | handshake             | payload
// in      | in  | in_valid/in_stall     | set_index, first_value, second_value, last
// out     | out | out_valid/out_stall   | report_set .. empty_res
// cfg     | in  | cfg_we                | cfg_data (select_second)
// plain items are taken one per cycle while the input does not stall; per-set state lives in one ram, read then written
// back-to-back items of the same set are forwarded from the write stage
// a last item stalls the input while the report unit works through its steps
// (5 multiply steps, the variance step, two 128-step divides, the square root search); an empty set skips them
// reset clears the state ram with one entry per cycle, all NUM_SETS entries
// output stall holds the report unit, which holds the input
`default_nettype none
module masked_score_statistics_core #(
	parameter int unsigned NUM_SETS = mss_pkg::NUM_SETS_DEF,
	parameter int unsigned MAX_SAMPLES = mss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  set_index,
	input  wire logic signed [23:0] first_value,
	input  wire logic signed [23:0] second_value,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       report_set,
	output logic [23:0]      min_value,
	output logic [22:0]      max_value,
	output logic [23:0]      mean_value,
	output logic [23:0]      std_dev,
	output logic [16:0]      valid_count,
	output logic             empty_res
);
	import mss_pkg::*;
	`include "masked_score_statistics_core_defines.svh"
	localparam int unsigned AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned RD = 1 << AW;

	logic sel_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= 1'b0;
		else if (cfg_we) sel_q <= cfg_data;
	end

	// clearing sweep after reset
	logic [AW:0] clr_q;
	logic        clearing;
	assign clearing = !clr_q[AW] && (clr_q < (AW+1)'(NUM_SETS));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + 1'b1;
	end

	logic rep_busy, rep_take;
	logic s1_q, s1_last_q;
	logic [AW-1:0] s1_set_q;
	logic [23:0]   s1_v_q;
	logic in_take, in_ok;
	assign in_ok = (32'(set_index) < NUM_SETS);
	// the input stalls while clearing, while the report unit is busy and while a last item is in the write stage
	assign in_stall = clearing || rep_busy || (s1_q && s1_last_q);
	assign in_take = in_valid && !in_stall;

	// stage 1: read request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_q <= 1'b0;
		else s1_q <= in_take && in_ok;
	end
	always_ff @(posedge clk) begin
		s1_set_q <= AW'(set_index);
		s1_last_q <= in_take && in_ok && last;
		s1_v_q <= sel_q ? second_value : first_value;
	end

	entry_t rd, cur, nxt, fwd_q;
	logic fwd_hit_q;
	logic [AW-1:0] fset_q;
	logic we;
	logic [AW-1:0] waddr;
	entry_t wdata;
	logic [47:0] vsq;

	mss_ram #(.WIDTH(ENT_W), .DEPTH(RD)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(AW'(set_index)), .rdata(rd)
	);

	// forward from the previous write of the same set
	always_ff @(posedge clk) begin
		fwd_hit_q <= we && (waddr == AW'(set_index));
		fwd_q <= wdata;
	end
	assign cur = fwd_hit_q ? fwd_q : rd;

	// 24x24 square of the score
	assign vsq = s1_v_q * s1_v_q;

	// modify
	always_comb begin
		nxt = cur;
		if (!s1_v_q[23] && (32'(cur.cnt) < MAX_SAMPLES)) begin
			if (s1_v_q < cur.min_v) nxt.min_v = s1_v_q;
			if (s1_v_q[22:0] > cur.max_v) nxt.max_v = s1_v_q[22:0];
			nxt.sum = cur.sum + {16'd0, s1_v_q};
			nxt.sq = cur.sq + {16'd0, vsq};
			nxt.cnt = cur.cnt + 1'b1;
		end
	end

	assign we = clearing || s1_q;
	assign waddr = clearing ? clr_q[AW-1:0] : s1_set_q;
	assign wdata = (clearing || s1_last_q) ? clear_entry() : nxt;

	rep_req_t rq;
	assign rq = '{set: 2'(s1_set_q), min_v: nxt.min_v, max_v: nxt.max_v,
		sum: nxt.sum, sq: nxt.sq, cnt: nxt.cnt};
	assign rep_take = s1_q && s1_last_q;

	mss_report u_rep (
		.clk(clk), .arst_n(arst_n), .req_valid(rep_take), .req(rq),
		.busy(rep_busy), .valid(out_valid), .stall(out_stall),
		.report_set(report_set), .min_value(min_value), .max_value(max_value),
		.mean_value(mean_value), .std_dev(std_dev), .valid_count(valid_count),
		.empty_res(empty_res)
	);

	`MSS_ASSERT_IMPL(a_no_take_clear, clearing, !in_take)
	`MSS_ASSERT_NEXT(a_last_blocks, rep_take, in_stall)
	`MSS_ASSERT_IMPL(a_no_take_busy, rep_busy, !in_take)
endmodule
`default_nettype wire

### test/masked_score_statistics_core_test.sv
// testbench for the masked score statistics core
`timescale 1ns / 100ps
`default_nettype none
module masked_score_statistics_core_test;
	import mss_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 150;

	// one report of a score set
	typedef struct packed {
		logic [SET_W-1:0]  set;
		logic [VAL_W-1:0]  min_v;
		logic [MAXV_W-1:0] max_v;
		logic [VAL_W-1:0]  mean;
		logic [VAL_W-1:0]  dev;
		logic [CNT_W-1:0]  cnt;
		logic              empty;
	} report_t;

	// one directed request, with an optional typed report
	typedef struct {
		logic [1:0]         set;
		logic signed [23:0] first;
		logic signed [23:0] second;
		logic               fin;
		bit                 typed;
		report_t            rep;
	} step_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] set_index = '0;
	logic signed [23:0] first_value = '0;
	logic signed [23:0] second_value = '0;
	logic last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] report_set;
	logic [23:0] min_value;
	logic [22:0] max_value;
	logic [23:0] mean_value;
	logic [23:0] std_dev;
	logic [16:0] valid_count;
	logic empty_res;

	// model state
	logic [VAL_W-1:0]  score_min [NUM_SETS_DEF];
	logic [MAXV_W-1:0] score_max [NUM_SETS_DEF];
	logic [SUM_W-1:0]  score_sum [NUM_SETS_DEF];
	logic [SQ_W-1:0]   score_sq [NUM_SETS_DEF];
	logic [CNT_W-1:0]  score_cnt [NUM_SETS_DEF];
	bit use_second = 0;

	report_t pending_reports[$];
	bit cur_typed = 0;
	report_t cur_report;
	bit req_typed = 0;
	report_t req_report;
	int errors = 0;
	int quiet_cycles = 0;
	bit idling = 1;
	bit hold_request = 0;

	masked_score_statistics_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .set_index(set_index),
		.first_value(first_value), .second_value(second_value), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .report_set(report_set),
		.min_value(min_value), .max_value(max_value), .mean_value(mean_value),
		.std_dev(std_dev), .valid_count(valid_count), .empty_res(empty_res)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_scores(int s);
		score_min[s] = '1;
		score_max[s] = '0;
		score_sum[s] = '0;
		score_sq[s] = '0;
		score_cnt[s] = '0;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// population deviation from count, sum and sum of squares
	function automatic logic [63:0] spread(logic [CNT_W-1:0] n, logic [SUM_W-1:0] s1,
			logic [SQ_W-1:0] s2);
		logic [127:0] a;
		logic [127:0] b;
		a = 128'(n) * 128'(s2);
		b = 128'(s1) * 128'(s1);
		a = (a < b) ? 128'd0 : a - b;
		a = a / 128'(n);
		a = a / 128'(n);
		return floor_sqrt(a[63:0]);
	endfunction

	// fold one pair into its set; returns 1 with a report on the last pair
	function automatic bit accumulate_scores(logic [1:0] s, logic [23:0] a, logic [23:0] b,
			logic fin, output report_t rep);
		logic [23:0] v;
		v = use_second ? b : a;
		if (!v[23] && score_cnt[s] < CNT_W'(MAX_SAMPLES_DEF)) begin
			if (v < score_min[s])
				score_min[s] = v;
			if (v[22:0] > score_max[s])
				score_max[s] = v[22:0];
			score_sum[s] = score_sum[s] + SUM_W'(v);
			score_sq[s] = score_sq[s] + SQ_W'(v) * SQ_W'(v);
			score_cnt[s] = score_cnt[s] + 1'b1;
		end
		rep = '0;
		if (!fin)
			return 0;
		rep.set = s;
		rep.cnt = score_cnt[s];
		if (score_cnt[s] == 0) begin
			rep.min_v = '1;
			rep.max_v = '0;
			rep.mean = '1;
			rep.dev = '1;
			rep.empty = 1;
		end else begin
			rep.min_v = score_min[s];
			rep.max_v = score_max[s];
			rep.mean = VAL_W'(score_sum[s] / SUM_W'(score_cnt[s]));
			rep.dev = VAL_W'(spread(score_cnt[s], score_sum[s], score_sq[s]));
			rep.empty = 0;
		end
		clear_scores(s);
		return 1;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// accept requests, predict, and check reports
	always @(posedge clk) begin
		report_t rep;
		report_t want;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (in_valid && !in_stall) begin
				moved = 1;
				if (accumulate_scores(set_index, first_value, second_value, last, rep))
					pending_reports.push_back(req_typed ? req_report : rep);
			end
			if (out_valid && !out_stall) begin
				moved = 1;
				if (pending_reports.size() == 0) begin
					report_mismatch("unexpected report_set", report_set, 0);
				end else begin
					want = pending_reports.pop_front();
					if (report_set !== want.set)
						report_mismatch("report_set", report_set, want.set);
					if (min_value !== want.min_v)
						report_mismatch("min_value", min_value, want.min_v);
					if (max_value !== want.max_v)
						report_mismatch("max_value", max_value, want.max_v);
					if (mean_value !== want.mean)
						report_mismatch("mean_value", mean_value, want.mean);
					if (std_dev !== want.dev)
						report_mismatch("std_dev", std_dev, want.dev);
					if (valid_count !== want.cnt)
						report_mismatch("valid_count", valid_count, want.cnt);
					if (empty_res !== want.empty)
						report_mismatch("empty_res", empty_res, want.empty);
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("masked_score_statistics_core_test: done, errors");
				$finish;
			end
		end
	end

	// receiver with random stall bursts and one long hold
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_stall <= 1;
				hold_request = 0;
				repeat (600) @(posedge clk);
				out_stall <= 0;
				@(posedge clk);
			end else if (idling && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(1, 20);
				out_stall <= 0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// offer one request and hold it until taken
	task automatic send_request(logic [1:0] s, logic [23:0] a, logic [23:0] b, logic fin);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1;
		set_index <= s;
		first_value <= a;
		second_value <= b;
		last <= fin;
		req_typed <= cur_typed;
		req_report <= cur_report;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_select(logic v);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		use_second = v;
	endtask

	function automatic logic [23:0] random_score();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 15));
			2: return {1'b0, 23'($urandom)};
			default: return 24'($urandom_range(0, 1 << 16));
		endcase
	endfunction

	task automatic random_requests(int count);
		for (int i = 0; i < count; i++)
			send_request(2'($urandom), random_score(), random_score(),
				$urandom_range(0, 6) == 0);
	endtask

	step_t steps[$];
	report_t empty_rep;
	report_t r;

	// stimulus
	initial begin
		for (int s = 0; s < NUM_SETS_DEF; s++)
			clear_scores(s);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		// directed table
		empty_rep = '{set: 0, min_v: '1, max_v: 0, mean: '1, dev: '1, cnt: 0, empty: 1};
		steps.push_back('{0, -24'sd1, 24'sd5, 1, 1, empty_rep});
		r = '{set: 1, min_v: 0, max_v: 0, mean: 0, dev: 0, cnt: 1, empty: 0};
		steps.push_back('{1, 24'sd0, -24'sd1, 1, 1, r});
		r = '{set: 2, min_v: 24'h7fffff, max_v: 23'h7fffff, mean: 24'h7fffff, dev: 0,
			cnt: 1, empty: 0};
		steps.push_back('{2, 24'sh7fffff, 24'sd0, 1, 1, r});
		empty_rep.set = 3;
		steps.push_back('{3, 24'sh800000, 24'sd100, 1, 1, empty_rep});
		steps.push_back('{0, 24'sd5, 24'sd0, 0, 0, '0});
		steps.push_back('{0, -24'sd3, 24'sd9, 0, 0, '0});
		steps.push_back('{0, 24'sh7fffff, 24'sh800000, 0, 0, '0});
		steps.push_back('{0, 24'sd1, 24'sd2, 1, 0, '0});
		steps.push_back('{1, 24'sd100, 24'sd1, 0, 0, '0});
		steps.push_back('{2, 24'sd200, 24'sd1, 0, 0, '0});
		steps.push_back('{1, 24'sd300, 24'sd1, 1, 0, '0});
		steps.push_back('{2, 24'sd400, 24'sd1, 1, 0, '0});
		steps.push_back('{3, 24'sh555555, 24'shaaaaaa, 0, 0, '0});
		steps.push_back('{3, 24'sh2aaaaa, 24'sh7fffff, 1, 0, '0});
		foreach (steps[i]) begin
			cur_typed = steps[i].typed;
			cur_report = steps[i].rep;
			send_request(steps[i].set, steps[i].first, steps[i].second, steps[i].fin);
		end
		cur_typed = 0;

		// random phases across both select settings
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			write_select(p % 2 == 0);
			if (p == 1)
				hold_request = 1;
			random_requests(PHASE_ITEMS / 2);
			if (p == 2)
				wait_drained();
			random_requests(PHASE_ITEMS / 2);
		end

		// final stretch, no idling from here on
		wait_drained();
		write_select(0);
		idling = 0;
		send_request(0, 24'sd7, 24'sd0, 1);
		random_requests(30);

		wait_drained();
		if (errors == 0) begin
			$display("masked_score_statistics_core_test: done, clean");
		end else begin
			$display("masked_score_statistics_core_test: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
